// ----- rtl/core/spq_pkg.sv -----
// Shared types and codes for the stable priority queue block.
// No dependencies; used by spq_ctrl, spq_dp and the top level.
package spq_pkg;

    localparam logic [1:0] CMD_ENQ   = 2'd0;
    localparam logic [1:0] CMD_DRAIN = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic enq;
        logic query;
        logic drain_empty;
        logic drain_step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic last_one;
    } dp_status_t;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
// Controller state machine: input handshake and drain sequencing.
// Depends on spq_pkg; drives spq_dp through dp_cmd_t.
module spq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  spq_pkg::dp_status_t dp_status,
    output spq_pkg::dp_cmd_t    dp_cmd
);

    spq_pkg::state_t state_reg;
    spq_pkg::state_t state_next;
    logic            accept;

    assign in_stall = !(state_reg == spq_pkg::S_IDLE && dp_status.out_free);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (accept && cmd == spq_pkg::CMD_DRAIN && !dp_status.empty)
                begin
                    state_next = spq_pkg::S_DRAIN;
                end
            end
            spq_pkg::S_DRAIN:
            begin
                if (dp_status.out_free && dp_status.last_one)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd = '0;
        unique case (state_reg)
            spq_pkg::S_IDLE:
            begin
                dp_cmd.enq         = accept && cmd == spq_pkg::CMD_ENQ;
                dp_cmd.query       = accept && cmd == spq_pkg::CMD_QUERY;
                dp_cmd.drain_empty = accept && cmd == spq_pkg::CMD_DRAIN
                                     && dp_status.empty;
            end
            spq_pkg::S_DRAIN:
            begin
                dp_cmd.drain_step = dp_status.out_free;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/spq_dp.sv -----
// Datapath: sorted shift-register queue, running id min/max, output register.
// Depends on spq_pkg; commanded by spq_ctrl.
module spq_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::dp_cmd_t    dp_cmd,
    output spq_pkg::dp_status_t dp_status,
    input  logic [15:0]         event_id,
    input  logic [7:0]          prio,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [1:0]          status,
    output logic [15:0]         out_id,
    output logic [7:0]          out_prio,
    output logic                last,
    output logic [15:0]         min_id,
    output logic [15:0]         max_id,
    output logic                have_drained
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [ID_BITS-1:0]   ids_reg   [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   ids_next  [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] prios_reg [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] prios_next[QUEUE_DEPTH];
    logic [ID_BITS-1:0]   ids_up    [QUEUE_DEPTH];
    logic [PRIO_BITS-1:0] prios_up  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0] le_ext;

    logic [CW-1:0]        count_reg, count_next;
    logic [ID_BITS-1:0]   lowest_reg, lowest_next;
    logic [ID_BITS-1:0]   highest_reg, highest_next;
    logic                 any_reg, any_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          out_id_reg, out_id_next;
    logic [7:0]           out_prio_reg, out_prio_next;
    logic                 last_reg, last_next;

    logic [ID_BITS-1:0]   id_in;
    logic [PRIO_BITS-1:0] prio_in;
    logic                 full;
    logic                 load;
    logic [ID_BITS-1:0]   head_id;
    logic [ID_BITS-1:0]   drain_lo, drain_hi;

    assign id_in   = ID_BITS'(event_id);
    assign prio_in = PRIO_BITS'(prio);
    assign full    = count_reg >= CW'(QUEUE_DEPTH);
    assign head_id = ids_reg[0];

    assign dp_status.out_free = !out_valid_reg || !out_stall;
    assign dp_status.empty    = count_reg == '0;
    assign dp_status.last_one = count_reg == CW'(1);

    assign drain_lo = (!any_reg || head_id < lowest_reg)  ? head_id : lowest_reg;
    assign drain_hi = (!any_reg || head_id > highest_reg) ? head_id : highest_reg;

    always_comb
    begin
        le_ext[0] = 1'b1;
        ids_up[0]   = id_in;
        prios_up[0] = prio_in;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            le_ext[i+1] = (CW'(i) < count_reg) && (prios_reg[i] <= prio_in);
        end
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            ids_up[i]   = ids_reg[i-1];
            prios_up[i] = prios_reg[i-1];
        end
    end

    always_comb
    begin
        ids_next   = ids_reg;
        prios_next = prios_reg;
        count_next = count_reg;
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        any_next     = any_reg;
        if (dp_cmd.enq && !full)
        begin
            count_next = count_reg + CW'(1);
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (le_ext[i+1])
                begin
                    ids_next[i]   = ids_reg[i];
                    prios_next[i] = prios_reg[i];
                end
                else if (le_ext[i])
                begin
                    ids_next[i]   = id_in;
                    prios_next[i] = prio_in;
                end
                else
                begin
                    ids_next[i]   = ids_up[i];
                    prios_next[i] = prios_up[i];
                end
            end
        end
        else if (dp_cmd.drain_step)
        begin
            count_next   = count_reg - CW'(1);
            lowest_next  = drain_lo;
            highest_next = drain_hi;
            any_next     = 1'b1;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                ids_next[i]   = ids_reg[i+1];
                prios_next[i] = prios_reg[i+1];
            end
        end
    end

    assign load = dp_cmd.enq || dp_cmd.query || dp_cmd.drain_empty || dp_cmd.drain_step;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        out_prio_next  = out_prio_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_id_next    = '0;
            out_prio_next  = '0;
            last_next      = 1'b1;
            if (dp_cmd.enq)
            begin
                kind_next   = spq_pkg::KIND_ACK;
                status_next = full ? spq_pkg::STAT_FULL : spq_pkg::STAT_OK;
            end
            else if (dp_cmd.query)
            begin
                kind_next   = spq_pkg::KIND_REPORT;
                status_next = any_reg ? spq_pkg::STAT_OK : spq_pkg::STAT_EMPTY;
            end
            else if (dp_cmd.drain_empty)
            begin
                kind_next   = spq_pkg::KIND_ENTRY;
                status_next = spq_pkg::STAT_EMPTY;
            end
            else
            begin
                kind_next     = spq_pkg::KIND_ENTRY;
                status_next   = spq_pkg::STAT_OK;
                out_id_next   = 16'(head_id);
                out_prio_next = 8'(prios_reg[0]);
                last_next     = dp_status.last_one;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ids_reg      <= ids_next;
        prios_reg    <= prios_next;
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            lowest_reg    <= '0;
            highest_reg   <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            lowest_reg    <= lowest_next;
            highest_reg   <= highest_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // min/max on every beat reflect the update made by that beat
    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_prio     = out_prio_reg;
    assign last         = last_reg;
    assign min_id       = 16'(lowest_reg);
    assign max_id       = 16'(highest_reg);
    assign have_drained = any_reg;

endmodule

// ----- rtl/core/stable_priority_queue_minmax_top.sv -----
// Bounded stable priority queue with running min/max of drained ids.
// Enqueue and query are each answered by one beat, and one item can be
// accepted every cycle while the output side takes beats and no drain is
// under way; the sorted insert is a parallel compare across a shift-register
// queue. A drain of n entries takes the command, then shifts the queue head
// out one beat per cycle while the output side takes beats; an empty drain
// gives one beat, status empty. Equal priorities leave in arrival order.
// Top level: depends on spq_pkg, spq_ctrl, spq_dp.
module stable_priority_queue_minmax_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16,
    parameter int PRIO_BITS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] event_id,
    input  logic [7:0]  prio,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [15:0] out_id,
    output logic [7:0]  out_prio,
    output logic        last,
    output logic [15:0] min_id,
    output logic [15:0] max_id,
    output logic        have_drained
);

    spq_pkg::dp_cmd_t    dp_cmd;
    spq_pkg::dp_status_t dp_status;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    spq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .event_id     (event_id),
        .prio         (prio),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .status       (status),
        .out_id       (out_id),
        .out_prio     (out_prio),
        .last         (last),
        .min_id       (min_id),
        .max_id       (max_id),
        .have_drained (have_drained)
    );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for stable_priority_queue_minmax_top: mirrors the sorted queue and
// the drained-id min/max, checks every output beat. Depends on spq_pkg and the block's RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         DEPTH      = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         HOLD_AT    = 150;
    localparam int         HOLD_LEN   = 300;
    localparam int         LIMIT      = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] id;
        logic [7:0]  pr;
        logic        last;
        logic [15:0] lo;
        logic [15:0] hi;
        logic        any;
    } beat_t;

    typedef struct {
        logic [1:0]  c;
        logic [15:0] id;
        logic [7:0]  pr;
        bit          pause;
    } cmd_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = spq_pkg::CMD_ENQ;
    logic [15:0] event_id = '0;
    logic [7:0]  prio = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_prio;
    logic        last;
    logic [15:0] min_id;
    logic [15:0] max_id;
    logic        have_drained;

    stable_priority_queue_minmax_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .event_id     (event_id),
        .prio         (prio),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .status       (status),
        .out_id       (out_id),
        .out_prio     (out_prio),
        .last         (last),
        .min_id       (min_id),
        .max_id       (max_id),
        .have_drained (have_drained)
    );

    logic [15:0] mirror_ids   [DEPTH];
    logic [7:0]  mirror_prios [DEPTH];
    int          mirror_count = 0;
    logic [15:0] drained_lo = '0;
    logic [15:0] drained_hi = '0;
    logic        drained_any = 1'b0;

    beat_t       due_results [$];
    cmd_item_t   cmd_backlog [$];
    cmd_item_t   next_item;
    beat_t       got;
    beat_t       want;

    int          beats_in = 0;
    int          fail_count = 0;
    int          send_idle_pct = 18;
    int          recv_idle_pct = 50;
    int          hold_left = 0;
    bit          hold_started = 0;
    int          cycle_count = 0;

    function automatic void mirror_apply(input logic [1:0] c, input logic [15:0] id,
                                         input logic [7:0] pr);
        beat_t r;
        int    pos;
        int    i;
        r = '0;
        r.last = 1'b1;
        case (c)
            spq_pkg::CMD_ENQ:
            begin
                r.kind = spq_pkg::KIND_ACK;
                if (mirror_count >= DEPTH)
                begin
                    r.status = spq_pkg::STAT_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < mirror_count && mirror_prios[pos] <= pr)
                        pos++;
                    for (i = mirror_count; i > pos; i--)
                    begin
                        mirror_ids[i]   = mirror_ids[i-1];
                        mirror_prios[i] = mirror_prios[i-1];
                    end
                    mirror_ids[pos]   = id;
                    mirror_prios[pos] = pr;
                    mirror_count++;
                    r.status = spq_pkg::STAT_OK;
                end
                r.lo  = drained_lo;
                r.hi  = drained_hi;
                r.any = drained_any;
                due_results.push_back(r);
            end
            spq_pkg::CMD_DRAIN:
            begin
                r.kind = spq_pkg::KIND_ENTRY;
                if (mirror_count == 0)
                begin
                    r.status = spq_pkg::STAT_EMPTY;
                    r.lo     = drained_lo;
                    r.hi     = drained_hi;
                    r.any    = drained_any;
                    due_results.push_back(r);
                end
                else
                begin
                    for (i = 0; i < mirror_count; i++)
                    begin
                        if (!drained_any)
                        begin
                            drained_lo  = mirror_ids[i];
                            drained_hi  = mirror_ids[i];
                            drained_any = 1'b1;
                        end
                        else
                        begin
                            if (mirror_ids[i] < drained_lo)
                                drained_lo = mirror_ids[i];
                            if (mirror_ids[i] > drained_hi)
                                drained_hi = mirror_ids[i];
                        end
                        r.status = spq_pkg::STAT_OK;
                        r.id     = mirror_ids[i];
                        r.pr     = mirror_prios[i];
                        r.last   = (i + 1 == mirror_count);
                        r.lo     = drained_lo;
                        r.hi     = drained_hi;
                        r.any    = drained_any;
                        due_results.push_back(r);
                    end
                    mirror_count = 0;
                end
            end
            spq_pkg::CMD_QUERY:
            begin
                r.kind   = spq_pkg::KIND_REPORT;
                r.status = drained_any ? spq_pkg::STAT_OK : spq_pkg::STAT_EMPTY;
                r.lo     = drained_lo;
                r.hi     = drained_hi;
                r.any    = drained_any;
                due_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(input logic [1:0] c, input logic [15:0] id,
                                    input logic [7:0] pr, input bit pause = 0);
        cmd_item_t it;
        it.c     = c;
        it.id    = id;
        it.pr    = pr;
        it.pause = pause;
        cmd_backlog.push_back(it);
    endfunction

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: present queued beats, hold them while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd      <= spq_pkg::CMD_ENQ;
            event_id <= '0;
            prio     <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                mirror_apply(cmd, event_id, prio);
                beats_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                    !(cmd_backlog[0].pause && due_results.size() != 0))
                begin
                    next_item = cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= next_item.c;
                    event_id <= next_item.id;
                    prio     <= next_item.pr;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result beats, drive output stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.kind   = kind;
                got.status = status;
                got.id     = out_id;
                got.pr     = out_prio;
                got.last   = last;
                got.lo     = min_id;
                got.hi     = max_id;
                got.any    = have_drained;
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected beat: kind=%0d status=%0d id=%h prio=%h last=%b",
                                 got.kind, got.status, got.id, got.pr, got.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display({"mismatch exp: kind=%0d st=%0d id=%h pr=%h last=%b",
                                      " min=%h max=%h have=%b"},
                                     want.kind, want.status, want.id, want.pr, want.last,
                                     want.lo, want.hi, want.any);
                            $display({"         got: kind=%0d st=%0d id=%h pr=%h last=%b",
                                      " min=%h max=%h have=%b"},
                                     got.kind, got.status, got.id, got.pr, got.last,
                                     got.lo, got.hi, got.any);
                        end
                    end
                end
            end
            if (!hold_started && beats_in >= HOLD_AT)
            begin
                hold_started = 1;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stable_priority_queue_minmax_top test failed");
        $finish;
    end

    initial
    begin
        int          total;
        int          n;
        int          k;
        int          roll;
        bit          ties;
        logic [15:0] id;
        logic [7:0]  pr;

        // nothing drained yet, empty drain, ignored code
        add_cmd(spq_pkg::CMD_QUERY, 16'h0000, 8'h00);
        add_cmd(spq_pkg::CMD_DRAIN, 16'hFFFF, 8'hFF);
        add_cmd(CMD_UNUSED, 16'hA5A5, 8'h5A);
        add_cmd(spq_pkg::CMD_ENQ, 16'hFFFF, 8'hFF);
        add_cmd(spq_pkg::CMD_ENQ, 16'h0000, 8'h00);
        add_cmd(spq_pkg::CMD_ENQ, 16'h0007, 8'h80);
        add_cmd(spq_pkg::CMD_ENQ, 16'h0008, 8'h80);
        add_cmd(spq_pkg::CMD_DRAIN, 16'h0000, 8'h00);
        add_cmd(spq_pkg::CMD_QUERY, 16'h0000, 8'h00);
        // fill to depth with ties, then one over
        for (k = 0; k < DEPTH; k++)
            add_cmd(spq_pkg::CMD_ENQ, 16'(16'h1000 + k),
                    (k % 3 == 0) ? 8'hFF : 8'(k % 2));
        add_cmd(spq_pkg::CMD_ENQ, 16'hBEEF, 8'h00);
        add_cmd(spq_pkg::CMD_DRAIN, 16'h0000, 8'h00);

        add_cmd(spq_pkg::CMD_QUERY, 16'h0000, 8'h00, 1);
        while (cmd_backlog.size() < 490)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                n    = ($urandom_range(9) == 0) ? $urandom_range(14, 19)
                                                : $urandom_range(1, 8);
                ties = $urandom_range(1);
                for (k = 0; k < n; k++)
                begin
                    if (ties)
                        pr = $urandom_range(1) ? 8'($urandom_range(2))
                                               : 8'(8'hFF - $urandom_range(1));
                    else
                        pr = 8'($urandom);
                    case ($urandom_range(15))
                        0:       id = 16'h0000;
                        1:       id = 16'hFFFF;
                        default: id = 16'($urandom);
                    endcase
                    add_cmd(spq_pkg::CMD_ENQ, id, pr, cmd_backlog.size() == 300);
                end
                add_cmd(spq_pkg::CMD_DRAIN, 16'($urandom), 8'($urandom));
                if ($urandom_range(3) == 0)
                    add_cmd(spq_pkg::CMD_QUERY, 16'($urandom), 8'($urandom));
            end
            else if (roll < 95)
            begin
                add_cmd(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
            end
            else
            begin
                add_cmd(spq_pkg::CMD_QUERY, 16'($urandom), 8'($urandom));
            end
        end
        total = cmd_backlog.size();

        while (beats_in < total / 3)
            @(posedge clk);
        send_idle_pct = 50;
        recv_idle_pct = 18;
        while (beats_in < 2 * total / 3)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        while (cmd_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (due_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("stable_priority_queue_minmax_top test passed");
        else
            $display("stable_priority_queue_minmax_top test failed");
        $finish;
    end

endmodule
